// ===== hdl/dmpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmpa_pkg;

    localparam logic [7:0] PWM_TOP = 8'd255;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CRUISE_SPEED = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_DUTY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BACK_TICKS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_TURN_TICKS = 3'd5;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    localparam logic signed [15:0] CMD_MAX = 16'sd255;
    localparam logic signed [15:0] CMD_MIN = -16'sd255;

    typedef enum logic [4:0] {
        STEP_IDLE = 5'b00001,
        STEP_LEFT = 5'b00010,
        STEP_RIGHT = 5'b00100,
        STEP_BACK = 5'b01000,
        STEP_ESCAPE = 5'b10000
    } step_t;

    typedef struct packed {
        logic command_valid;
        logic signed [15:0] left_command;
        logic signed [15:0] right_command;
        logic left_sensor;
        logic right_sensor;
    } in_t;

    typedef struct packed {
        logic [1:0] left_direction;
        logic [1:0] right_direction;
        logic left_enable;
        logic right_enable;
        logic avoiding;
    } out_t;

    typedef struct packed {
        logic [7:0] cruise_speed;
        logic [7:0] deadband;
        logic [7:0] idle_duty;
        logic [15:0] turn_ticks;
        logic [15:0] back_ticks;
        logic [15:0] escape_turn_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [8:0] left_value;
        logic signed [8:0] right_value;
        logic avoiding;
    } seq_drive_t;

    function automatic logic signed [8:0] clamp_cmd(input logic signed [15:0] v);
        if (v > CMD_MAX) begin
            return 9'sd255;
        end else if (v < CMD_MIN) begin
            return -9'sd255;
        end else begin
            return v[8:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dmpa_drive.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmpa_drive (
    input  wire logic signed [8:0] value,
    input  wire logic [7:0]        deadband,
    input  wire logic [7:0]        idle_duty,
    output logic [1:0]             direction,
    output logic [7:0]             duty
);

    logic signed [9:0] value_ext;
    logic signed [9:0] db_pos;
    logic signed [9:0] db_neg;
    logic signed [9:0] magnitude;

    always_comb begin
        value_ext = {value[8], value};
        db_pos = $signed({2'b00, deadband});
        db_neg = -db_pos;
        magnitude = -value_ext;
        if (value_ext < db_neg) begin
            direction = dmpa_pkg::DIR_BACK;
            duty = magnitude[7:0];
        end else if (value_ext > db_pos) begin
            direction = dmpa_pkg::DIR_FWD;
            duty = value_ext[7:0];
        end else begin
            direction = dmpa_pkg::DIR_STOP;
            duty = idle_duty;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dmpa_pwm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmpa_pwm (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic [7:0] duty,
    output logic            enable
);

    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] count_inc;

    always_comb begin
        count_inc = count_reg + 8'd1;
        enable = (count_inc < duty);
        count_next = (count_inc >= dmpa_pkg::PWM_TOP) ? 8'd0 : count_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 8'd0;
        end else if (advance) begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dmpa_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmpa_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire dmpa_pkg::in_t     item,
    input  wire dmpa_pkg::cfg_t    cfg,
    output dmpa_pkg::seq_drive_t   drive
);

    dmpa_pkg::step_t step_reg;
    dmpa_pkg::step_t step_next;
    dmpa_pkg::step_t step_eff;
    logic [15:0] timer_reg;
    logic [15:0] timer_next;
    logic [15:0] timer_eff;
    logic [15:0] timer_dec;
    logic signed [8:0] held_left_reg;
    logic signed [8:0] held_left_next;
    logic signed [8:0] held_right_reg;
    logic signed [8:0] held_right_next;
    logic signed [8:0] cur_left;
    logic signed [8:0] cur_right;
    logic signed [8:0] pos_c;
    logic signed [8:0] neg_c;
    logic lfire;
    logic rfire;
    logic end_seq;

    function automatic logic [15:0] at_least_one(input logic [15:0] ticks);
        return (ticks == 16'd0) ? 16'd1 : ticks;
    endfunction

    always_comb begin
        lfire = !item.left_sensor;
        rfire = !item.right_sensor;
        pos_c = $signed({1'b0, cfg.cruise_speed});
        neg_c = -pos_c;
        cur_left = item.command_valid ? dmpa_pkg::clamp_cmd(item.left_command) : held_left_reg;
        cur_right = item.command_valid ? dmpa_pkg::clamp_cmd(item.right_command)
                                       : held_right_reg;

        step_eff = step_reg;
        timer_eff = timer_reg;
        if (step_reg == dmpa_pkg::STEP_IDLE && (lfire || rfire)) begin
            if (rfire && !lfire) begin
                step_eff = dmpa_pkg::STEP_LEFT;
                timer_eff = at_least_one(cfg.turn_ticks);
            end else if (lfire && !rfire) begin
                step_eff = dmpa_pkg::STEP_RIGHT;
                timer_eff = at_least_one(cfg.turn_ticks);
            end else begin
                step_eff = dmpa_pkg::STEP_BACK;
                timer_eff = at_least_one(cfg.back_ticks);
            end
        end
        timer_dec = timer_eff - 16'd1;

        step_next = step_eff;
        timer_next = timer_dec;
        held_left_next = cur_left;
        held_right_next = cur_right;
        drive.left_value = cur_left;
        drive.right_value = cur_right;
        drive.avoiding = 1'b1;
        end_seq = 1'b0;

        case (step_eff)
            dmpa_pkg::STEP_IDLE: begin
                drive.avoiding = 1'b0;
                timer_next = timer_reg;
            end
            dmpa_pkg::STEP_LEFT: begin
                drive.left_value = neg_c;
                drive.right_value = pos_c;
                if (timer_dec == 16'd0) begin
                    if (lfire && !rfire) begin
                        step_next = dmpa_pkg::STEP_RIGHT;
                        timer_next = at_least_one(cfg.turn_ticks);
                    end else if (lfire && rfire) begin
                        step_next = dmpa_pkg::STEP_BACK;
                        timer_next = at_least_one(cfg.back_ticks);
                    end else begin
                        end_seq = 1'b1;
                    end
                end
            end
            dmpa_pkg::STEP_RIGHT: begin
                drive.left_value = pos_c;
                drive.right_value = neg_c;
                if (timer_dec == 16'd0) begin
                    if (lfire && rfire) begin
                        step_next = dmpa_pkg::STEP_BACK;
                        timer_next = at_least_one(cfg.back_ticks);
                    end else begin
                        end_seq = 1'b1;
                    end
                end
            end
            dmpa_pkg::STEP_BACK: begin
                drive.left_value = neg_c;
                drive.right_value = neg_c;
                if (timer_dec == 16'd0) begin
                    step_next = dmpa_pkg::STEP_ESCAPE;
                    timer_next = at_least_one(cfg.escape_turn_ticks);
                end
            end
            dmpa_pkg::STEP_ESCAPE: begin
                drive.left_value = pos_c;
                drive.right_value = neg_c;
                if (timer_dec == 16'd0) begin
                    end_seq = 1'b1;
                end
            end
            default: begin
                end_seq = 1'b1;
            end
        endcase

        if (end_seq) begin
            step_next = dmpa_pkg::STEP_IDLE;
            timer_next = 16'd0;
            held_left_next = 9'sd0;
            held_right_next = 9'sd0;
            drive.left_value = 9'sd0;
            drive.right_value = 9'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= dmpa_pkg::STEP_IDLE;
            timer_reg <= 16'd0;
            held_left_reg <= 9'sd0;
            held_right_reg <= 9'sd0;
        end else if (advance) begin
            step_reg <= step_next;
            timer_reg <= timer_next;
            held_left_reg <= held_left_next;
            held_right_reg <= held_right_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dual_motor_pwm_with_avoidance.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Moves
// input     s_valid, s_ready, s_data (in_t)        one tick request
// result    m_valid, m_ready, m_data (out_t)       one drive result per tick
// config    cfg_wr_en, cfg_index, cfg_wdata        register write, no handshake
//
// One request is accepted every cycle unless the result stalls.
// The input register and the result register bound one combinational pass.
// Reset clears the sequencer, held commands, PWM counters and valid flags,
// and loads the register defaults.
// A stalled result holds, one more request waits in the input register,
// and then s_ready drops until the result is taken.

module dual_motor_pwm_with_avoidance (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire dmpa_pkg::in_t                      s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output dmpa_pkg::out_t                          m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [dmpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [dmpa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    dmpa_pkg::cfg_t cfg_reg;
    dmpa_pkg::in_t in_data_reg;
    logic in_valid_reg;
    logic in_valid_next;
    dmpa_pkg::out_t m_data_reg;
    dmpa_pkg::out_t m_data_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic advance;
    dmpa_pkg::seq_drive_t drive;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic [1:0] left_dir;
    logic [1:0] right_dir;
    logic left_en;
    logic right_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cruise_speed <= 8'd128;
            cfg_reg.deadband <= 8'd20;
            cfg_reg.idle_duty <= 8'd20;
            cfg_reg.turn_ticks <= 16'd400;
            cfg_reg.back_ticks <= 16'd400;
            cfg_reg.escape_turn_ticks <= 16'd900;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dmpa_pkg::REG_CRUISE_SPEED: cfg_reg.cruise_speed <= cfg_wdata[7:0];
                dmpa_pkg::REG_DEADBAND: cfg_reg.deadband <= cfg_wdata[7:0];
                dmpa_pkg::REG_IDLE_DUTY: cfg_reg.idle_duty <= cfg_wdata[7:0];
                dmpa_pkg::REG_TURN_TICKS: cfg_reg.turn_ticks <= cfg_wdata;
                dmpa_pkg::REG_BACK_TICKS: cfg_reg.back_ticks <= cfg_wdata;
                dmpa_pkg::REG_ESCAPE_TURN_TICKS: cfg_reg.escape_turn_ticks <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        advance = in_valid_reg && (!m_valid_reg || m_ready);
        s_ready = !in_valid_reg || advance;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
        m_data_next.left_direction = left_dir;
        m_data_next.right_direction = right_dir;
        m_data_next.left_enable = left_en;
        m_data_next.right_enable = right_en;
        m_data_next.avoiding = drive.avoiding;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    dmpa_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .drive   (drive)
    );

    dmpa_drive u_drive_left (
        .value     (drive.left_value),
        .deadband  (cfg_reg.deadband),
        .idle_duty (cfg_reg.idle_duty),
        .direction (left_dir),
        .duty      (left_duty)
    );

    dmpa_drive u_drive_right (
        .value     (drive.right_value),
        .deadband  (cfg_reg.deadband),
        .idle_duty (cfg_reg.idle_duty),
        .direction (right_dir),
        .duty      (right_duty)
    );

    dmpa_pwm u_pwm_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .duty    (left_duty),
        .enable  (left_en)
    );

    dmpa_pwm u_pwm_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .duty    (right_duty),
        .enable  (right_en)
    );

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed request produced no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("waiting request lost from input register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.left_direction != 2'b11
                        && m_data_reg.right_direction != 2'b11)
        else $error("undefined direction code in result");

endmodule

`default_nettype wire
